// ===== src/least_loaded_core_task_dispatcher_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LEAST_LOADED_CORE_TASK_DISPATCHER_MACROS_SVH
`define LEAST_LOADED_CORE_TASK_DISPATCHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LLCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LLCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`endif

// ===== src/llcd_pkg.sv =====
package llcd_pkg;

  // Request operation codes.
  localparam logic [2:0] OP_SPAWN    = 3'd0;
  localparam logic [2:0] OP_RUN      = 3'd1;
  localparam logic [2:0] OP_SLEEP    = 3'd2;
  localparam logic [2:0] OP_SHUTDOWN = 3'd3;
  localparam logic [2:0] OP_SIZE     = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Result limit for one request and the width of its counter.
  localparam int MAX_RESULTS = 64;
  localparam int K_W         = 7;
  localparam int NC_W        = 4;

  // Core address selects for the per-core state port.
  localparam logic [1:0] SEL_CID  = 2'd0;
  localparam logic [1:0] SEL_SCAN = 2'd1;
  localparam logic [1:0] SEL_BEST = 2'd2;
  localparam logic [1:0] SEL_CUR  = 2'd3;

  // Result core field sources.
  localparam logic [1:0] CORE_NONE = 2'd0;
  localparam logic [1:0] CORE_CID  = 2'd1;
  localparam logic [1:0] CORE_BEST = 2'd2;
  localparam logic [1:0] CORE_CUR  = 2'd3;

  // Result task field sources.
  localparam logic [1:0] TASK_NONE  = 2'd0;
  localparam logic [1:0] TASK_TID   = 2'd1;
  localparam logic [1:0] TASK_RDATA = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_in;
    logic [1:0] caddr_sel;
    logic       rd_en;
    logic       rd_rear;
    logic       scan_start;
    logic       scan_step;
    logic       pop_front;
    logic       pop_rear;
    logic       push;
    logic       push_rdata;
    logic       tot_inc;
    logic       tot_dec;
    logic       cur_start;
    logic       cur_inc;
    logic       k_inc;
    logic       rem_cap;
    logic       emit;
    logic [1:0] em_st;
    logic [1:0] em_core;
    logic [1:0] em_task;
    logic       em_cnt;
    logic       em_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       tid_zero;
    logic       nc_zero;
    logic       nc_lt2;
    logic       cid_bad;
    logic       cnt_zero;
    logic       scan_done;
    logic       best_full;
    logic       rem_zero;
    logic       out_free;
    logic       total_zero;
    logic       total_one;
    logic       k_last;
    logic       k_full;
  } dp_stat_t;

endpackage

// ===== src/least_loaded_core_task_dispatcher.sv =====
// Channel    Direction  Handshake           Payload
// request    in         in_valid/in_stall   op, task_id, core_id
// result     out        out_valid/out_stall status, core_num, task_num, task_count, last
// config     in         cfg_write           cfg_data (num_cores)
//
// Size query and bad requests answer from the decode state; run reads the task, then answers.
// Spawn answers after the one-core-per-cycle load search.
// Sleep runs one load search per moved task.
// Shutdown deletes each task in turn and passes over empty cores.
// Reset (rst, synchronous) clears all queues and num_cores; no clearing pass.
// A stalled result holds the block at its next result until the stalled one is taken.
module least_loaded_core_task_dispatcher #(
  parameter int CORES = 8,
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [15:0] task_id,
  input  logic [3:0]  core_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  core_num,
  output logic [15:0] task_num,
  output logic [3:0]  task_count,
  output logic        last,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data
);

  llcd_pkg::dp_cmd_t  cmd;
  llcd_pkg::dp_stat_t stat;

  // Sequencer for each request.
  llcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queues, task store, load search and result register.
  llcd_datapath #(
    .CORES (CORES),
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .task_id    (task_id),
    .core_id    (core_id),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .core_num   (core_num),
    .task_num   (task_num),
    .task_count (task_count),
    .last       (last)
  );

endmodule

// ===== src/llcd_ctrl.sv =====
module llcd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  llcd_pkg::dp_stat_t stat,
  output llcd_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_SCD  = 4'd3;
  localparam logic [3:0] S_MV   = 4'd4;
  localparam logic [3:0] S_PUSH = 4'd5;
  localparam logic [3:0] S_RUN  = 4'd6;
  localparam logic [3:0] S_SDC  = 4'd7;
  localparam logic [3:0] S_SDP  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       mv_last;
  logic       sd_last;

  assign in_stall = (state != S_IDLE);
  assign mv_last  = stat.rem_zero || stat.k_last;
  assign sd_last  = stat.total_one || stat.k_last;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DEC;
        end
      end

      S_DEC: begin
        cmd.caddr_sel = llcd_pkg::SEL_CID;
        cmd.em_last   = 1'b1;
        if (stat.out_free) begin
          case (stat.op)
            llcd_pkg::OP_SPAWN: begin
              if (stat.tid_zero || stat.nc_zero) begin
                cmd.emit   = 1'b1;
                cmd.em_st  = llcd_pkg::ST_FAIL;
                state_next = S_IDLE;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            llcd_pkg::OP_RUN: begin
              if (stat.cid_bad) begin
                cmd.emit   = 1'b1;
                cmd.em_st  = llcd_pkg::ST_FAIL;
                state_next = S_IDLE;
              end else if (stat.cnt_zero) begin
                cmd.emit    = 1'b1;
                cmd.em_st   = llcd_pkg::ST_EMPTY;
                cmd.em_core = llcd_pkg::CORE_CID;
                state_next  = S_IDLE;
              end else begin
                cmd.rd_en  = 1'b1;
                state_next = S_RUN;
              end
            end
            llcd_pkg::OP_SLEEP: begin
              if (stat.cid_bad) begin
                cmd.emit   = 1'b1;
                cmd.em_st  = llcd_pkg::ST_FAIL;
                state_next = S_IDLE;
              end else if (stat.cnt_zero) begin
                cmd.emit    = 1'b1;
                cmd.em_st   = llcd_pkg::ST_EMPTY;
                cmd.em_core = llcd_pkg::CORE_CID;
                state_next  = S_IDLE;
              end else if (stat.nc_lt2) begin
                cmd.emit    = 1'b1;
                cmd.em_st   = llcd_pkg::ST_FAIL;
                cmd.em_core = llcd_pkg::CORE_CID;
                state_next  = S_IDLE;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            llcd_pkg::OP_SHUTDOWN: begin
              if (stat.total_zero) begin
                cmd.emit   = 1'b1;
                cmd.em_st  = llcd_pkg::ST_EMPTY;
                state_next = S_IDLE;
              end else begin
                cmd.cur_start = 1'b1;
                state_next    = S_SDC;
              end
            end
            llcd_pkg::OP_SIZE: begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
              if (stat.cid_bad) begin
                cmd.em_st = llcd_pkg::ST_FAIL;
              end else begin
                cmd.em_st   = llcd_pkg::ST_OK;
                cmd.em_core = llcd_pkg::CORE_CID;
                cmd.em_cnt  = 1'b1;
              end
            end
            default: begin
              cmd.emit   = 1'b1;
              cmd.em_st  = llcd_pkg::ST_FAIL;
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // One core per cycle through the least-loaded search.
      S_SCAN: begin
        cmd.caddr_sel = llcd_pkg::SEL_SCAN;
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_SCD;
        end
      end

      S_SCD: begin
        if (stat.op == llcd_pkg::OP_SPAWN) begin
          cmd.caddr_sel = llcd_pkg::SEL_BEST;
          cmd.em_core   = llcd_pkg::CORE_BEST;
          cmd.em_task   = llcd_pkg::TASK_TID;
          cmd.em_last   = 1'b1;
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
            if (stat.best_full) begin
              cmd.em_st = llcd_pkg::ST_FAIL;
            end else begin
              cmd.em_st   = llcd_pkg::ST_OK;
              cmd.push    = 1'b1;
              cmd.tot_inc = 1'b1;
            end
          end
        end else begin
          // Fetch the rear task of the sleeping core.
          cmd.caddr_sel = llcd_pkg::SEL_CID;
          cmd.rd_en     = 1'b1;
          cmd.rd_rear   = 1'b1;
          state_next    = S_MV;
        end
      end

      S_MV: begin
        cmd.caddr_sel = llcd_pkg::SEL_CID;
        if (stat.best_full) begin
          cmd.em_st   = llcd_pkg::ST_FAIL;
          cmd.em_core = llcd_pkg::CORE_BEST;
          cmd.em_task = llcd_pkg::TASK_RDATA;
          cmd.em_last = 1'b1;
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.pop_rear = 1'b1;
          cmd.rem_cap  = 1'b1;
          state_next   = S_PUSH;
        end
      end

      S_PUSH: begin
        cmd.caddr_sel  = llcd_pkg::SEL_BEST;
        cmd.em_st      = llcd_pkg::ST_OK;
        cmd.em_core    = llcd_pkg::CORE_BEST;
        cmd.em_task    = llcd_pkg::TASK_RDATA;
        cmd.em_last    = mv_last;
        if (stat.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_rdata = 1'b1;
          cmd.emit       = 1'b1;
          cmd.k_inc      = 1'b1;
          if (mv_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end

      S_RUN: begin
        cmd.caddr_sel = llcd_pkg::SEL_CID;
        cmd.em_st     = llcd_pkg::ST_OK;
        cmd.em_core   = llcd_pkg::CORE_CID;
        cmd.em_task   = llcd_pkg::TASK_RDATA;
        cmd.em_last   = 1'b1;
        if (stat.out_free) begin
          cmd.pop_front = 1'b1;
          cmd.tot_dec   = 1'b1;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end
      end

      // Shutdown: find the next core holding tasks.
      S_SDC: begin
        cmd.caddr_sel = llcd_pkg::SEL_CUR;
        if (stat.cnt_zero) begin
          cmd.cur_inc = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_rear = 1'b1;
          state_next  = S_SDP;
        end
      end

      // Shutdown: delete the rear task, reported until the limit is reached.
      S_SDP: begin
        cmd.caddr_sel = llcd_pkg::SEL_CUR;
        cmd.em_st     = llcd_pkg::ST_OK;
        cmd.em_core   = llcd_pkg::CORE_CUR;
        cmd.em_task   = llcd_pkg::TASK_RDATA;
        cmd.em_last   = sd_last;
        if (stat.k_full || stat.out_free) begin
          cmd.pop_rear = 1'b1;
          cmd.tot_dec  = 1'b1;
          cmd.emit     = !stat.k_full;
          cmd.k_inc    = !stat.k_full;
          state_next   = stat.total_one ? S_IDLE : S_SDC;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/llcd_datapath.sv =====
module llcd_datapath #(
  parameter int CORES = 8,
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  llcd_pkg::dp_cmd_t  cmd,
  output llcd_pkg::dp_stat_t stat,
  input  logic [2:0]         op,
  input  logic [15:0]        task_id,
  input  logic [3:0]         core_id,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [2:0]         core_num,
  output logic [15:0]        task_num,
  output logic [3:0]         task_count,
  output logic               last
);

  localparam int XW    = $clog2(CORES);
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SLOTS = CORES * DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW    = $clog2(SLOTS + 1);

  logic [llcd_pkg::NC_W-1:0] nc;
  logic [2:0]                op_r;
  logic [15:0]               tid_r;
  logic [3:0]                cid_r;
  logic [XW-1:0]             cur;
  logic [XW-1:0]             best;
  logic [CW-1:0]             bestcnt;
  logic                      best_v;
  logic [XW-1:0]             scan_i;
  logic [llcd_pkg::K_W-1:0]  k;
  logic                      rem_zero;
  logic [TW-1:0]             total;
  logic [PW-1:0]             head [CORES];
  logic [PW-1:0]             tail [CORES];
  logic [CW-1:0]             cnt  [CORES];
  logic [15:0]               store [SLOTS];
  logic [15:0]               rdata;

  logic [XW-1:0] craw;
  logic [XW-1:0] caddr;
  logic [CW-1:0] c_cnt;
  logic [PW-1:0] c_head;
  logic [PW-1:0] c_tail;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;
  logic [PW-1:0] tail_dec;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [15:0]   push_data;
  logic          skip_hit;
  logic          out_free;

  // Per-core state port address, held in range for any core count.
  always_comb begin
    case (cmd.caddr_sel)
      llcd_pkg::SEL_CID:  craw = XW'(cid_r);
      llcd_pkg::SEL_SCAN: craw = scan_i;
      llcd_pkg::SEL_BEST: craw = best;
      llcd_pkg::SEL_CUR:  craw = cur;
      default:            craw = '0;
    endcase
    caddr = (32'(craw) < CORES) ? craw : '0;
  end

  assign c_cnt  = cnt[caddr];
  assign c_head = head[caddr];
  assign c_tail = tail[caddr];

  // Circular pointer steps.
  assign head_inc = (32'(c_head) == DEPTH - 1) ? '0 : PW'(32'(c_head) + 1);
  assign tail_inc = (32'(c_tail) == DEPTH - 1) ? '0 : PW'(32'(c_tail) + 1);
  assign tail_dec = (c_tail == '0) ? PW'(DEPTH - 1) : PW'(32'(c_tail) - 1);

  // Slot addresses: core row times depth plus the slot within the row.
  assign rd_addr   = AW'(32'(caddr) * DEPTH + 32'(cmd.rd_rear ? tail_dec : c_head));
  assign wr_addr   = AW'(32'(caddr) * DEPTH + 32'(c_tail));
  assign push_data = cmd.push_rdata ? rdata : tid_r;

  // Task store with registered read.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[wr_addr] <= push_data;
    end
    if (cmd.rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  // Request latch and scratch registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= op;
      tid_r <= task_id;
      cid_r <= core_id;
    end
    if (cmd.rem_cap) begin
      rem_zero <= (32'(c_cnt) == 1);
    end
  end

  assign skip_hit = (op_r == llcd_pkg::OP_SLEEP) && (32'(scan_i) == 32'(cid_r));

  // Control state: configuration, counters, search and per-core queues.
  always_ff @(posedge clk) begin
    if (rst) begin
      nc     <= '0;
      cur    <= '0;
      best   <= '0;
      bestcnt <= '0;
      best_v <= 1'b0;
      scan_i <= '0;
      k      <= '0;
      total  <= '0;
      for (int j = 0; j < CORES; j++) begin
        head[j] <= '0;
        tail[j] <= '0;
        cnt[j]  <= '0;
      end
    end else begin
      if (cfg_write && (nc == '0)) begin
        nc <= (32'(cfg_data) > CORES) ? llcd_pkg::NC_W'(CORES) : cfg_data;
      end
      if (cmd.latch_in) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.cur_start) begin
        cur <= '0;
      end else if (cmd.cur_inc) begin
        cur <= cur + 1'b1;
      end
      if (cmd.tot_inc) begin
        total <= total + 1'b1;
      end else if (cmd.tot_dec) begin
        total <= total - 1'b1;
      end
      // Least-loaded search, lowest index kept on ties.
      if (cmd.scan_start) begin
        scan_i <= '0;
        best_v <= 1'b0;
      end else if (cmd.scan_step) begin
        if (!skip_hit && (!best_v || (c_cnt < bestcnt))) begin
          best    <= scan_i;
          bestcnt <= c_cnt;
          best_v  <= 1'b1;
        end
        scan_i <= scan_i + 1'b1;
      end
      if (cmd.pop_front) begin
        head[caddr] <= head_inc;
        cnt[caddr]  <= c_cnt - 1'b1;
      end
      if (cmd.pop_rear) begin
        tail[caddr] <= tail_dec;
        cnt[caddr]  <= c_cnt - 1'b1;
      end
      if (cmd.push) begin
        tail[caddr] <= tail_inc;
        cnt[caddr]  <= c_cnt + 1'b1;
      end
    end
  end

  // Output register.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status     <= cmd.em_st;
      task_count <= cmd.em_cnt ? 4'(c_cnt) : 4'd0;
      last       <= cmd.em_last;
      case (cmd.em_core)
        llcd_pkg::CORE_CID:  core_num <= 3'(cid_r);
        llcd_pkg::CORE_BEST: core_num <= 3'(best);
        llcd_pkg::CORE_CUR:  core_num <= 3'(cur);
        default:             core_num <= 3'd0;
      endcase
      case (cmd.em_task)
        llcd_pkg::TASK_TID:   task_num <= tid_r;
        llcd_pkg::TASK_RDATA: task_num <= rdata;
        default:              task_num <= 16'd0;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.op         = op_r;
    stat.tid_zero   = (tid_r == 16'd0);
    stat.nc_zero    = (nc == '0);
    stat.nc_lt2     = (32'(nc) < 2);
    stat.cid_bad    = (cid_r >= nc);
    stat.cnt_zero   = (c_cnt == '0);
    stat.scan_done  = (32'(scan_i) + 1 == 32'(nc));
    stat.best_full  = (32'(bestcnt) >= DEPTH);
    stat.rem_zero   = rem_zero;
    stat.out_free   = out_free;
    stat.total_zero = (total == '0);
    stat.total_one  = (32'(total) == 1);
    stat.k_last     = (32'(k) == llcd_pkg::MAX_RESULTS - 1);
    stat.k_full     = (32'(k) == llcd_pkg::MAX_RESULTS);
  end

endmodule

// ===== src/llcd_checker.sv =====
`include "least_loaded_core_task_dispatcher_macros.svh"

module llcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [2:0]  core_num,
  input logic [15:0] task_num,
  input logic [3:0]  task_count,
  input logic        last
);

  // A stalled result stays offered.
  `LLCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled result keeps its payload.
  `LLCD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(core_num) && $stable(task_num) && $stable(task_count) && $stable(last))

  // Status never carries the unused code.
  `LLCD_ASSERT_NOW(a_status_code, out_valid, status != 2'd3)

  // A no-tasks result carries no task and no count, and ends its request.
  `LLCD_ASSERT_NOW(a_empty_fields, out_valid && (status == 2'd2), (task_num == 16'd0) && (task_count == 4'd0) && last)

endmodule

bind least_loaded_core_task_dispatcher llcd_checker u_llcd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .core_num   (core_num),
  .task_num   (task_num),
  .task_count (task_count),
  .last       (last)
);

// ===== test/least_loaded_core_task_dispatcher_tb.sv =====
`timescale 1ns / 1ps

module least_loaded_core_task_dispatcher_tb;

  localparam int CORES = 8;
  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 600000;

  // Reserved operation codes that the block must reject.
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  core_num;
    logic [15:0] task_num;
    logic [3:0]  task_count;
    logic        last;
  } dispatch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = '0;
  logic [15:0] task_id = '0;
  logic [3:0]  core_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [2:0]  core_num;
  logic [15:0] task_num;
  logic [3:0]  task_count;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [3:0]  cfg_data = '0;

  least_loaded_core_task_dispatcher #(.CORES(CORES), .DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .task_id(task_id), .core_id(core_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .core_num(core_num), .task_num(task_num),
    .task_count(task_count), .last(last),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  // Shadow copy of the dispatcher state.
  logic [15:0] mdl_store [CORES][DEPTH];
  int          mdl_head [CORES];
  int          mdl_tail [CORES];
  int          mdl_count [CORES];
  int          mdl_cores;

  dispatch_result_t expected_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    dispatch_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, core_num, task_num, task_count, last};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Least-loaded core in use, skipping one; CORES when none qualifies.
  function automatic int lightest_core(int skip);
    int best = CORES;
    for (int i = 0; i < mdl_cores; i++) begin
      if (i != skip && (best == CORES || mdl_count[i] < mdl_count[best])) best = i;
    end
    return best;
  endfunction

  // Work out the results of one request and update the shadow state.
  task automatic predict_dispatch(logic [2:0] req_op, logic [15:0] tid, logic [3:0] cid);
    dispatch_result_t res [$];
    int t;
    logic [15:0] v;
    case (req_op)
      llcd_pkg::OP_SPAWN: begin
        if (tid == 0 || mdl_cores == 0) begin
          res.push_back('{llcd_pkg::ST_FAIL, 3'd0, 16'd0, 4'd0, 1'b0});
        end else begin
          t = lightest_core(CORES);
          if (mdl_count[t] >= DEPTH) begin
            res.push_back('{llcd_pkg::ST_FAIL, 3'(t), tid, 4'd0, 1'b0});
          end else begin
            mdl_store[t][mdl_tail[t]] = tid;
            mdl_tail[t] = (mdl_tail[t] + 1) % DEPTH;
            mdl_count[t]++;
            res.push_back('{llcd_pkg::ST_OK, 3'(t), tid, 4'd0, 1'b0});
          end
        end
      end
      llcd_pkg::OP_RUN: begin
        if (cid >= mdl_cores) begin
          res.push_back('{llcd_pkg::ST_FAIL, 3'd0, 16'd0, 4'd0, 1'b0});
        end else if (mdl_count[cid] == 0) begin
          res.push_back('{llcd_pkg::ST_EMPTY, 3'(cid), 16'd0, 4'd0, 1'b0});
        end else begin
          v = mdl_store[cid][mdl_head[cid]];
          mdl_head[cid] = (mdl_head[cid] + 1) % DEPTH;
          mdl_count[cid]--;
          res.push_back('{llcd_pkg::ST_OK, 3'(cid), v, 4'd0, 1'b0});
        end
      end
      llcd_pkg::OP_SLEEP: begin
        if (cid >= mdl_cores) begin
          res.push_back('{llcd_pkg::ST_FAIL, 3'd0, 16'd0, 4'd0, 1'b0});
        end else if (mdl_count[cid] == 0) begin
          res.push_back('{llcd_pkg::ST_EMPTY, 3'(cid), 16'd0, 4'd0, 1'b0});
        end else if (mdl_cores < 2) begin
          res.push_back('{llcd_pkg::ST_FAIL, 3'(cid), 16'd0, 4'd0, 1'b0});
        end else begin
          // Move tasks from the rear until the core is empty, a target is full or the result limit is reached.
          while (mdl_count[cid] > 0 && res.size() < llcd_pkg::MAX_RESULTS) begin
            t = lightest_core(cid);
            v = mdl_store[cid][(mdl_tail[cid] + DEPTH - 1) % DEPTH];
            if (mdl_count[t] >= DEPTH) begin
              res.push_back('{llcd_pkg::ST_FAIL, 3'(t), v, 4'd0, 1'b0});
              break;
            end
            mdl_tail[cid] = (mdl_tail[cid] + DEPTH - 1) % DEPTH;
            mdl_count[cid]--;
            mdl_store[t][mdl_tail[t]] = v;
            mdl_tail[t] = (mdl_tail[t] + 1) % DEPTH;
            mdl_count[t]++;
            res.push_back('{llcd_pkg::ST_OK, 3'(t), v, 4'd0, 1'b0});
          end
        end
      end
      llcd_pkg::OP_SHUTDOWN: begin
        for (int c = 0; c < mdl_cores; c++) begin
          while (mdl_count[c] > 0) begin
            mdl_tail[c] = (mdl_tail[c] + DEPTH - 1) % DEPTH;
            mdl_count[c]--;
            if (res.size() < llcd_pkg::MAX_RESULTS)
              res.push_back('{llcd_pkg::ST_OK, 3'(c), mdl_store[c][mdl_tail[c]],
                              4'd0, 1'b0});
          end
          mdl_head[c] = 0;
          mdl_tail[c] = 0;
        end
        if (res.size() == 0)
          res.push_back('{llcd_pkg::ST_EMPTY, 3'd0, 16'd0, 4'd0, 1'b0});
      end
      llcd_pkg::OP_SIZE: begin
        if (cid >= mdl_cores)
          res.push_back('{llcd_pkg::ST_FAIL, 3'd0, 16'd0, 4'd0, 1'b0});
        else
          res.push_back('{llcd_pkg::ST_OK, 3'(cid), 16'd0, 4'(mdl_count[cid]), 1'b0});
      end
      default: res.push_back('{llcd_pkg::ST_FAIL, 3'd0, 16'd0, 4'd0, 1'b0});
    endcase
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // Offer one request, sometimes after a random gap, and wait until it is taken.
  task automatic send_request(logic [2:0] req_op, logic [15:0] tid, logic [3:0] cid);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= req_op;
    task_id <= tid;
    core_id <= cid;
    do @(posedge clk); while (in_stall);
    predict_dispatch(req_op, tid, cid);
    requests_sent++;
  endtask

  // Drop valid, let the block go quiet, then let it settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write; the shadow follows the ignore-once-set rule.
  task automatic write_num_cores(logic [3:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (mdl_cores == 0) mdl_cores = (value > CORES) ? CORES : value;
  endtask

  // Random request with mostly valid content and some malformed ones.
  task automatic send_random_request();
    int pick = $urandom_range(99);
    logic [3:0] cid = ($urandom_range(9) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
    logic [15:0] tid = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
    if (pick < 45)      send_request(llcd_pkg::OP_SPAWN, tid, cid);
    else if (pick < 65) send_request(llcd_pkg::OP_RUN, 16'($urandom), cid);
    else if (pick < 75) send_request(llcd_pkg::OP_SLEEP, 16'($urandom), cid);
    else if (pick < 88) send_request(llcd_pkg::OP_SIZE, 16'($urandom), cid);
    else if (pick < 92) send_request(llcd_pkg::OP_SHUTDOWN, 16'($urandom), cid);
    else send_request(3'($urandom_range(OP_RSVD_A, OP_RSVD_C)), tid, cid);
  endtask

  // Every operation before any core is set up.
  task automatic test_unconfigured();
    send_request(llcd_pkg::OP_SPAWN, 16'd5, 4'd0);
    send_request(llcd_pkg::OP_RUN, 16'd0, 4'd0);
    send_request(llcd_pkg::OP_SLEEP, 16'd0, 4'd0);
    send_request(llcd_pkg::OP_SIZE, 16'd0, 4'd0);
    send_request(llcd_pkg::OP_SHUTDOWN, 16'd0, 4'd0);
    send_request(OP_RSVD_A, 16'd0, 4'd0);
    wait_drained();
  endtask

  // Field extremes and the special cases on a configured block.
  task automatic test_directed();
    write_num_cores(4'd0);
    write_num_cores(4'd15);
    write_num_cores(4'd1);
    send_request(llcd_pkg::OP_SHUTDOWN, 16'd0, 4'd0);
    send_request(llcd_pkg::OP_SPAWN, 16'd0, 4'd0);
    send_request(llcd_pkg::OP_SPAWN, 16'hFFFF, 4'd15);
    send_request(llcd_pkg::OP_SPAWN, 16'd1, 4'd0);
    send_request(llcd_pkg::OP_SPAWN, 16'h8000, 4'd0);
    send_request(llcd_pkg::OP_SIZE, 16'd0, 4'd0);
    send_request(llcd_pkg::OP_SIZE, 16'd0, 4'd7);
    send_request(llcd_pkg::OP_SIZE, 16'd0, 4'd8);
    send_request(llcd_pkg::OP_RUN, 16'd0, 4'd15);
    send_request(llcd_pkg::OP_RUN, 16'd0, 4'd7);
    send_request(llcd_pkg::OP_RUN, 16'd0, 4'd0);
    send_request(llcd_pkg::OP_SLEEP, 16'd0, 4'd5);
    send_request(llcd_pkg::OP_SLEEP, 16'd0, 4'd1);
    send_request(llcd_pkg::OP_SLEEP, 16'd0, 4'd9);
    send_request(OP_RSVD_B, 16'hFFFF, 4'd15);
    send_request(OP_RSVD_C, 16'd7, 4'd3);
    send_request(llcd_pkg::OP_SHUTDOWN, 16'd0, 4'd0);
    wait_drained();
  endtask

  // Fill every core, then hit the full cases of spawn and sleep.
  task automatic test_full_cores();
    for (int i = 0; i < CORES * DEPTH; i++)
      send_request(llcd_pkg::OP_SPAWN, 16'($urandom_range(1, 65535)), 4'd0);
    send_request(llcd_pkg::OP_SPAWN, 16'h1234, 4'd0);
    send_request(llcd_pkg::OP_SLEEP, 16'd0, 4'd3);
    send_request(llcd_pkg::OP_RUN, 16'd0, 4'd2);
    send_request(llcd_pkg::OP_SLEEP, 16'd0, 4'd6);
    send_request(llcd_pkg::OP_SHUTDOWN, 16'd0, 4'd0);
    wait_drained();
  endtask

  // Random traffic under one idling pattern.
  task automatic test_random_phase(int send_idle, int recv_stall, int n);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < n; i++) send_random_request();
    wait_drained();
    write_num_cores(4'($urandom));
  endtask

  // Long receiver hold-off while requests keep coming, so the input backs up.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 24; i++) send_random_request();
    wait_drained();
  endtask

  initial begin
    for (int c = 0; c < CORES; c++) begin
      mdl_head[c] = 0;
      mdl_tail[c] = 0;
      mdl_count[c] = 0;
    end
    mdl_cores = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unconfigured();
    test_directed();
    test_full_cores();
    test_random_phase(0, 0, 45);
    test_random_phase(73, 0, 45);
    test_random_phase(0, 73, 45);
    test_random_phase(13, 13, 45);
    test_backpressure();
    test_random_phase(0, 0, 25);
    repeat (50) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    $display("Sent %0d requests over spawn, run, sleep, shutdown and size queries,",
             requests_sent);
    $display("checked %0d results under idling, stalls and a long hold-off.", results_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
